// File: hw/rtl/cesd_pkg.sv
// ----------------------------------------------------------------------------
// cesd_pkg: shared types and constants of the C escape sequence decoder
// Decoder phases, result status codes, result record and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cesd_pkg;

  // Decoder phase, one-hot
  typedef enum logic [6:0] {
    PH_PLAIN = 7'b000_0001,
    PH_ESC   = 7'b000_0010,
    PH_HEX1  = 7'b000_0100,
    PH_HEX2  = 7'b000_1000,
    PH_OCT2  = 7'b001_0000,
    PH_OCT3  = 7'b010_0000,
    PH_DROP  = 7'b100_0000
  } phase_e;

  // Result status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIGIT = 2'd1,
    ST_EARLY_END = 2'd2
  } status_e;

  // Result queue sizing: an item may add two results while one waits
  localparam int unsigned QDepth = 3;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Digits gathered so far (two octal digits at most)
  localparam int unsigned PartW = 6;

  // Character codes
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LV     = 8'h76;
  localparam logic [7:0] CH_LX     = 8'h78;

  // Control codes
  localparam logic [7:0] CC_BEL = 8'h07;
  localparam logic [7:0] CC_BS  = 8'h08;
  localparam logic [7:0] CC_HT  = 8'h09;
  localparam logic [7:0] CC_LF  = 8'h0A;
  localparam logic [7:0] CC_VT  = 8'h0B;
  localparam logic [7:0] CC_FF  = 8'h0C;
  localparam logic [7:0] CC_CR  = 8'h0D;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       run_last;
    logic       string_done;
  } result_t;

  // Results produced by one item, handed to the result queue
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Hex digit: {valid, value}
  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [4:0] r;
    r = 5'b0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Octal digit: {valid, value}
  function automatic logic [3:0] oct_digit(logic [7:0] b);
    logic [3:0] r;
    r = 4'b0;
    if (b >= 8'h30 && b <= 8'h37) begin
      r = {1'b1, b[2:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cesd_decode.sv
// ----------------------------------------------------------------------------
// cesd_decode: escape decoding step
// Holds the phase and gathered digits; decodes the registered byte into up
// to two results and updates the state when the item is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module cesd_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  output cesd_pkg::push_t push_o
);
  import cesd_pkg::*;

  typedef struct packed {
    phase_e           phase;
    logic [PartW-1:0] part;
    push_t            push;
  } step_t;

  phase_e           phase_q;
  logic [PartW-1:0] part_q;
  step_t            st;
  logic [4:0]       hex;
  logic [3:0]       oct;

  // Single result, back to plain text
  function automatic step_t f_emit(logic [7:0] v, logic last);
    step_t s;
    s.phase        = PH_PLAIN;
    s.part         = '0;
    s.push.count   = 2'd1;
    s.push.first   = '{data: v, status: ST_OK, run_last: 1'b1, string_done: last};
    s.push.second  = s.push.first;
    return s;
  endfunction

  // Error result; drop rest of string unless it ends here
  function automatic step_t f_fail(status_e code, logic last);
    step_t s;
    s.phase        = last ? PH_PLAIN : PH_DROP;
    s.part         = '0;
    s.push.count   = 2'd1;
    s.push.first   = '{data: 8'h00, status: code, run_last: 1'b1, string_done: 1'b1};
    s.push.second  = s.push.first;
    return s;
  endfunction

  // Wait for more digits, or fail if the string ends here
  function automatic step_t f_await(phase_e nxt, logic [PartW-1:0] v, logic last);
    step_t s;
    if (last) begin
      s = f_fail(ST_EARLY_END, 1'b1);
    end else begin
      s.phase       = nxt;
      s.part        = v;
      s.push        = '0;
    end
    return s;
  endfunction

  // Next state and results for the current byte
  always_comb begin
    hex = hex_digit(byte_i);
    oct = oct_digit(byte_i);
    st.phase = phase_q;
    st.part  = part_q;
    st.push  = '0;
    unique case (phase_q)
      PH_ESC: begin
        unique case (byte_i) inside
          CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH: st = f_emit(byte_i, last_i);
          CH_LA: st = f_emit(CC_BEL, last_i);
          CH_LB: st = f_emit(CC_BS, last_i);
          CH_LF: st = f_emit(CC_FF, last_i);
          CH_LN: st = f_emit(CC_LF, last_i);
          CH_LR: st = f_emit(CC_CR, last_i);
          CH_LT: st = f_emit(CC_HT, last_i);
          CH_LV: st = f_emit(CC_VT, last_i);
          CH_LX: st = f_await(PH_HEX1, '0, last_i);
          default: begin
            if (oct[3]) begin
              st = f_await(PH_OCT2, PartW'(oct[2:0]), last_i);
            end else begin
              // unknown escape: backslash, then the byte itself
              st.phase       = PH_PLAIN;
              st.part        = '0;
              st.push.count  = 2'd2;
              st.push.first  = '{data: CH_BSLASH, status: ST_OK, run_last: 1'b0,
                                 string_done: 1'b0};
              st.push.second = '{data: byte_i, status: ST_OK, run_last: 1'b1,
                                 string_done: last_i};
            end
          end
        endcase
      end
      PH_HEX1: begin
        if (!hex[4]) st = f_fail(ST_BAD_DIGIT, last_i);
        else         st = f_await(PH_HEX2, PartW'(hex[3:0]), last_i);
      end
      PH_HEX2: begin
        if (!hex[4]) st = f_fail(ST_BAD_DIGIT, last_i);
        else         st = f_emit({part_q[3:0], hex[3:0]}, last_i);
      end
      PH_OCT2: begin
        if (!oct[3]) st = f_fail(ST_BAD_DIGIT, last_i);
        else         st = f_await(PH_OCT3, {part_q[2:0], oct[2:0]}, last_i);
      end
      PH_OCT3: begin
        // three octal digits wrap to 8 bits
        if (!oct[3]) st = f_fail(ST_BAD_DIGIT, last_i);
        else         st = f_emit({part_q[4:0], oct[2:0]}, last_i);
      end
      PH_DROP: begin
        if (last_i) begin
          st.phase = PH_PLAIN;
          st.part  = '0;
        end
      end
      default: begin
        // plain text, also any unused phase code
        if (byte_i == CH_BSLASH) begin
          if (last_i) begin
            st = f_emit(CH_BSLASH, 1'b1);
          end else begin
            st.phase = PH_ESC;
            st.part  = '0;
          end
        end else begin
          st = f_emit(byte_i, last_i);
        end
      end
    endcase
  end

  assign push_o = st.push;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      part_q  <= '0;
    end else if (fire_i) begin
      phase_q <= st.phase;
      part_q  <= st.part;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cesd_out_queue.sv
// ----------------------------------------------------------------------------
// cesd_out_queue: result queue
// Shift queue of result records; takes up to two per cycle, presents the
// head as the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cesd_out_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cesd_pkg::push_t                push_i,
  input  logic                           pop_i,
  output cesd_pkg::result_t              head_o,
  output logic [cesd_pkg::QCntW-1:0]     count_o
);
  import cesd_pkg::*;

  result_t          e_q [QDepth];
  result_t          e_d [QDepth];
  logic [QCntW-1:0] count_q;
  logic [QCntW-1:0] count_d;
  logic [QCntW-1:0] cnt_pop;
  logic [QCntW-1:0] cnt_pop1;

  // Shift on pop, then write new results behind the remaining ones
  always_comb begin
    cnt_pop  = count_q - QCntW'(pop_i);
    cnt_pop1 = cnt_pop + QCntW'(1);
    for (int i = 0; i < QDepth; i++) begin
      if (pop_i && (i < QDepth - 1)) e_d[i] = e_q[(i + 1) % QDepth];
      else                           e_d[i] = e_q[i];
      if (push_i.count != 2'd0 && cnt_pop == QCntW'(i)) e_d[i] = push_i.first;
      if (push_i.count == 2'd2 && cnt_pop1 == QCntW'(i)) e_d[i] = push_i.second;
    end
    count_d = cnt_pop + QCntW'(push_i.count);
  end

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Entries
  always_ff @(posedge clk_i) begin
    e_q <= e_d;
  end

  assign head_o  = e_q[0];
  assign count_o = count_q;

endmodule

`default_nettype wire

// File: hw/rtl/c_escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder: C string escape decoder
// Decodes an escaped string, one raw byte per transaction, into bytes.
// ----------------------------------------------------------------------------
//  channel | signals                                  | carries
//  --------+------------------------------------------+------------------------
//  in      | in_valid_i in_ready_o in_byte_i in_last_i | raw string bytes
//  out     | out_valid_o out_ready_i out_byte_o        | decoded bytes, status,
//          | status_o run_last_o string_done_o        | end markers
//
//  One byte per cycle while the queue has room; input register, then queue.
//  An unknown escape gives two results, but its opening backslash gives none,
//  so the three-entry result queue absorbs the pair and intake does not pause
//  while the output keeps pace.
//  Intake stops when the queue cannot take the next byte's results.
//  Reset returns the decoder to plain text with an empty queue.
// ----------------------------------------------------------------------------
`default_nettype none

module c_escape_sequence_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       run_last_o,
  output logic       string_done_o
);
  import cesd_pkg::*;

  logic             in_valid_q;
  logic [7:0]       byte_q;
  logic             last_q;
  logic             fire;
  logic             pop;
  push_t            dec_push;
  push_t            q_push;
  result_t          head;
  logic [QCntW-1:0] q_count;

  // Consume the registered byte when the queue has room for its results
  assign fire = in_valid_q &&
                ((QCntW + 1)'(q_count) + (QCntW + 1)'(dec_push.count) <=
                 (QCntW + 1)'(QDepth));
  assign in_ready_o = !in_valid_q || fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  cesd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (byte_q),
    .last_i (last_q),
    .push_o (dec_push)
  );

  // Only a consumed item pushes results
  always_comb begin
    q_push = dec_push;
    if (!fire) q_push.count = 2'd0;
  end

  assign pop = out_valid_o && out_ready_i;

  cesd_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (q_count)
  );

  assign out_valid_o   = (q_count != '0);
  assign out_byte_o    = head.data;
  assign status_o      = head.status;
  assign run_last_o    = head.run_last;
  assign string_done_o = head.string_done;

endmodule

`default_nettype wire

// File: hw/rtl/cesd_checker.sv
// ----------------------------------------------------------------------------
// cesd_checker: port checks for the C escape sequence decoder
// Watches both channels and the result fields; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cesd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       in_last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [1:0] status_o,
  input logic       run_last_o,
  input logic       string_done_o
);
  import cesd_pkg::*;

  // A waiting input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_byte_i) &&
    $stable(in_last_i))
    else $error("input changed while waiting");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(status_o) && $stable(run_last_o) && $stable(string_done_o))
    else $error("result changed while stalled");

  // Error results carry a zero byte and close the string
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
    out_byte_o == 8'h00 && run_last_o && string_done_o)
    else $error("error result with bad fields");

  // Only the first half of an unknown escape lacks run_last
  a_first_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |->
    out_byte_o == CH_BSLASH && status_o == ST_OK && !string_done_o)
    else $error("non-final result is not a plain backslash");

  // Unused status code never appears
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_BAD_DIGIT ||
    status_o == ST_EARLY_END)
    else $error("unused status code");

endmodule

bind c_escape_sequence_decoder cesd_checker u_cesd_checker (.*);

`default_nettype wire

// File: verif/c_escape_sequence_decoder_tb.sv
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_tb: self-checking bench for the C escape decoder
// Streams escaped strings through the decoder with random bursts, gaps and
// output stalls. A behavioral decoder predicts every result, and each result
// is checked field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder_tb;
  import cesd_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxPrinted = 50;

  // Digit and letter bounds used by the predictor, string builder and tests
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SEVEN   = 8'h37;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_G = 8'h67;
  localparam logic [7:0] CH_LOWER_Q = 8'h71;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] status_o;
  logic       run_last_o;
  logic       string_done_o;

  c_escape_sequence_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o)
  );

  // Clock, period 2
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predicted decoder state and pending decoded results
  phase_e      dec_phase = PH_PLAIN;
  logic [8:0]  dec_digits = '0;
  result_t     decoded_q[$];

  logic [7:0]  str_q[$];
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b0;
  bit          stall_on = 1'b0;
  logic [31:0] ready_pat = '1;
  logic [4:0]  pat_idx = '0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int hex_value(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic int oct_value(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_SEVEN) return int'(c - CH_ZERO);
    return -1;
  endfunction

  task automatic push_decoded(input logic [7:0] data, input status_e st,
                              input logic rl, input logic done);
    result_t r;
    r.data = data;
    r.status = st;
    r.run_last = rl;
    r.string_done = done;
    decoded_q.push_back(r);
  endtask

  task automatic emit_char(input logic [7:0] data, input logic last);
    dec_phase = PH_PLAIN;
    dec_digits = '0;
    push_decoded(data, ST_OK, 1'b1, last);
  endtask

  // Error result; the rest of the string is dropped unless it ends here
  task automatic emit_error(input status_e st, input logic last);
    dec_phase = last ? PH_PLAIN : PH_DROP;
    dec_digits = '0;
    push_decoded(8'h00, st, 1'b1, 1'b1);
  endtask

  task automatic await_digit(input phase_e nxt, input int val, input logic last);
    if (last) begin
      emit_error(ST_EARLY_END, 1'b1);
    end else begin
      dec_phase = nxt;
      dec_digits = 9'(val);
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    int hv;
    int ov;
    logic [8:0] sum;
    hv = hex_value(b);
    ov = oct_value(b);
    case (dec_phase)
      PH_ESC: begin
        case (b)
          CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH: emit_char(b, last);
          CH_LA: emit_char(CC_BEL, last);
          CH_LB: emit_char(CC_BS, last);
          CH_LF: emit_char(CC_FF, last);
          CH_LN: emit_char(CC_LF, last);
          CH_LR: emit_char(CC_CR, last);
          CH_LT: emit_char(CC_HT, last);
          CH_LV: emit_char(CC_VT, last);
          CH_LX: await_digit(PH_HEX1, 0, last);
          default: begin
            if (ov >= 0) begin
              await_digit(PH_OCT2, ov, last);
            end else begin
              // unknown escape: backslash, then the byte itself
              dec_phase = PH_PLAIN;
              dec_digits = '0;
              push_decoded(CH_BSLASH, ST_OK, 1'b0, 1'b0);
              push_decoded(b, ST_OK, 1'b1, last);
            end
          end
        endcase
      end
      PH_HEX1: begin
        if (hv < 0) emit_error(ST_BAD_DIGIT, last);
        else await_digit(PH_HEX2, hv, last);
      end
      PH_HEX2: begin
        if (hv < 0) emit_error(ST_BAD_DIGIT, last);
        else emit_char({dec_digits[3:0], 4'(hv)}, last);
      end
      PH_OCT2: begin
        if (ov < 0) emit_error(ST_BAD_DIGIT, last);
        else await_digit(PH_OCT3, int'(dec_digits[2:0]) * 8 + ov, last);
      end
      PH_OCT3: begin
        if (ov < 0) begin
          emit_error(ST_BAD_DIGIT, last);
        end else begin
          sum = {dec_digits[5:0], 3'(ov)};
          emit_char(sum[7:0], last);
        end
      end
      PH_DROP: begin
        if (last) begin
          dec_phase = PH_PLAIN;
          dec_digits = '0;
        end
      end
      default: begin
        if (b != CH_BSLASH) begin
          emit_char(b, last);
        end else if (last) begin
          emit_char(CH_BSLASH, 1'b1);
        end else begin
          dec_phase = PH_ESC;
          dec_digits = '0;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    in_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(b, last);
    items_sent++;
  endtask

  task automatic send_string();
    foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
    str_q.delete();
  endtask

  // Output side: stall pattern reloaded whenever the pattern index wraps
  always @(posedge clk_i) begin
    if (pat_idx == 0) begin
      ready_pat = ($urandom_range(0, 2) == 0) ? ($urandom & $urandom)
                                              : ($urandom | $urandom);
    end
    out_ready_i <= stall_on ? ready_pat[pat_idx] : 1'b1;
    pat_idx = pat_idx + 5'd1;
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MaxPrinted) $display("mismatch @%0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%02h status=%0d",
                                  out_byte_o, status_o));
      end else begin
        r = decoded_q.pop_front();
        if (out_byte_o !== r.data || status_o !== r.status ||
            run_last_o !== r.run_last || string_done_o !== r.string_done) begin
          report_mismatch($sformatf(
            "got byte=%02h st=%0d rl=%0b done=%0b, want byte=%02h st=%0d rl=%0b done=%0b",
            out_byte_o, status_o, run_last_o, string_done_o,
            r.data, r.status, r.run_last, r.string_done));
        end
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("c_escape_sequence_decoder_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // String building helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] simple_escape_char(int unsigned k);
    case (k)
      0: return CH_SQUOTE;
      1: return CH_DQUOTE;
      2: return CH_QMARK;
      3: return CH_BSLASH;
      4: return CH_LA;
      5: return CH_LB;
      6: return CH_LF;
      7: return CH_LN;
      8: return CH_LR;
      9: return CH_LT;
      default: return CH_LV;
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned k;
    k = $urandom_range(0, 21);
    if (k < 10) return CH_ZERO + 8'(k);
    if (k < 16) return CH_LA + 8'(k - 10);
    return CH_UPPER_A + 8'(k - 16);
  endfunction

  function automatic logic [7:0] oct_char();
    return CH_ZERO + 8'($urandom_range(0, 7));
  endfunction

  task automatic add_random_token();
    int unsigned r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      // plain byte, never a backslash
      c = 8'($urandom_range(0, 255));
      if (c == CH_BSLASH) c = ~c;
      str_q.push_back(c);
    end else if (r < 55) begin
      str_q.push_back(CH_BSLASH);
      str_q.push_back(simple_escape_char($urandom_range(0, 10)));
    end else if (r < 70) begin
      str_q.push_back(CH_BSLASH);
      str_q.push_back(CH_LX);
      str_q.push_back(hex_char());
      str_q.push_back(hex_char());
    end else if (r < 85) begin
      str_q.push_back(CH_BSLASH);
      str_q.push_back(oct_char());
      str_q.push_back(oct_char());
      str_q.push_back(oct_char());
    end else if (r < 93) begin
      str_q.push_back(CH_BSLASH);
      str_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      // escape broken by a (most likely) bad digit
      str_q.push_back(CH_BSLASH);
      if ($urandom_range(0, 1) == 1) begin
        str_q.push_back(CH_LX);
        if ($urandom_range(0, 1) == 1) str_q.push_back(hex_char());
      end else begin
        str_q.push_back(oct_char());
        if ($urandom_range(0, 1) == 1) str_q.push_back(oct_char());
      end
      str_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Escape cut short by the end of the string
  task automatic add_cut_tail();
    str_q.push_back(CH_BSLASH);
    case ($urandom_range(0, 4))
      0: ;
      1: str_q.push_back(CH_LX);
      2: begin
        str_q.push_back(CH_LX);
        str_q.push_back(hex_char());
      end
      3: str_q.push_back(oct_char());
      default: begin
        str_q.push_back(oct_char());
        str_q.push_back(oct_char());
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_plain_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_named_escapes();
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_LN, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_BSLASH, 1'b1);
  endtask

  task automatic test_hex_escape();
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_LX, 1'b0);
    send_byte(CH_UPPER_F, 1'b0);
    send_byte(CH_LF, 1'b0);
  endtask

  // \777 wraps to 8 bits
  task automatic test_octal_escape();
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_SEVEN, 1'b0);
    send_byte(CH_SEVEN, 1'b0);
    send_byte(CH_SEVEN, 1'b1);
  endtask

  task automatic test_unknown_escape();
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_LOWER_Q, 1'b1);
  endtask

  task automatic test_error_cases();
    // bad hex digit, rest of the string dropped
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_LX, 1'b0);
    send_byte(CH_LOWER_G, 1'b0);
    send_byte(CH_LA, 1'b1);
    // string ends inside an octal escape
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_ZERO + 8'd1, 1'b1);
    // trailing backslash
    send_byte(CH_BSLASH, 1'b1);
    // bad digit on the last byte wins over the early end
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_SEVEN, 1'b0);
    send_byte(CH_NINE, 1'b1);
  endtask

  task automatic test_random_strings(input int unsigned target);
    int unsigned n;
    while (items_sent < target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(1, 10);
      repeat (n) add_random_token();
      if ($urandom_range(0, 9) == 0) add_cut_tail();
      send_string();
    end
  endtask

  // Raw bytes biased toward escape characters, random string ends
  task automatic test_random_noise(input int unsigned target);
    int unsigned r;
    logic [7:0] c;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 30) c = CH_BSLASH;
      else if (r < 45) c = CH_LX;
      else if (r < 65) c = CH_ZERO + 8'($urandom_range(0, 9));
      else c = 8'($urandom_range(0, 255));
      send_byte(c, $urandom_range(0, 7) == 0);
    end
    // close any open string
    send_byte(CH_ZERO, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_bytes();
    test_named_escapes();
    test_hex_escape();
    test_octal_escape();
    gaps_on = 1'b1;
    stall_on = 1'b1;
    test_unknown_escape();
    test_error_cases();
    test_random_strings(1400);
    test_random_noise(1900);
    in_valid_i <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("c_escape_sequence_decoder_tb: done, clean");
    end else begin
      $display("c_escape_sequence_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
